/* src/middle_access_stack_core_defines.svh */
// Assertion macros for the middle access stack.
// Concurrent checks are compiled out when SYNTHESIS is defined.
`ifndef MIDDLE_ACCESS_STACK_CORE_DEFINES_SVH
`define MIDDLE_ACCESS_STACK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define MAS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/mas_pkg.sv */
package mas_pkg;

    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 7;
    localparam int DEPTH_DEF  = 64;
    localparam int GROUP_DEF  = 8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // per-cell control for one update cycle
    typedef struct packed {
        logic push_wr;  // load pushed word
        logic shift;    // take word from the cell above
        logic sel;      // cell sits at the middle index
    } t_cell_ctl;

endpackage

/* src/mas_cell.sv */
module mas_cell (
    input  logic                          i_clk,
    input  mas_pkg::t_cell_ctl            i_ctl,
    input  logic [mas_pkg::DATA_W-1:0]    i_push_value,
    input  logic [mas_pkg::DATA_W-1:0]    i_upper,
    output logic [mas_pkg::DATA_W-1:0]    o_data,
    output logic [mas_pkg::DATA_W-1:0]    o_tap
);

    logic [mas_pkg::DATA_W-1:0] r_data;
    logic [mas_pkg::DATA_W-1:0] r_tap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_wr) begin
            r_data <= i_push_value;
        end else if (i_ctl.shift) begin
            r_data <= i_upper;
        end
        // masked copy feeds the middle OR tree
        r_tap <= i_ctl.sel ? r_data : '0;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

/* src/mas_mid_tree.sv */
module mas_mid_tree #(
    parameter int DEPTH = mas_pkg::DEPTH_DEF,
    parameter int GROUP = mas_pkg::GROUP_DEF
) (
    input  logic                          i_clk,
    input  logic [mas_pkg::DATA_W-1:0]    i_taps [DEPTH],
    output logic [mas_pkg::DATA_W-1:0]    o_word
);

    localparam int NGRP = (DEPTH + GROUP - 1) / GROUP;

    logic [mas_pkg::DATA_W-1:0] r_grp [NGRP];
    logic [mas_pkg::DATA_W-1:0] n_grp [NGRP];
    logic [mas_pkg::DATA_W-1:0] n_sum;
    logic [mas_pkg::DATA_W-1:0] r_sum;

    // at most one tap is nonzero, so OR acts as the select
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_sum <= n_sum;
    end

    assign o_word = r_sum;

endmodule

/* src/middle_access_stack_core.sv */
// Bounded stack of signed 32-bit words with access to its middle entry.
// Each input transfer carries one operation (push, pop, read middle, delete
// middle); each produces exactly one output transfer with the middle entry
// after the operation (index count/2 from the bottom, zero when empty), a
// status (ok, empty, full) and the entry count. Entries live in a row of
// DEPTH cells; a delete makes each cell from the middle up to count-2 take the
// word of its upper neighbor in the same cycle, so the gap closes at once. The
// middle word is picked by the cells themselves (each masks its word unless
// it sits at the middle index) and gathered through a two-level registered
// OR tree. One item is in flight at a time: the input is accepted, the cells
// update in the next cycle, the tap, group and sum registers then gather the
// middle word, and the result is held on the output until taken.
// No clearing pass is needed after reset: only entries below the count are
// ever read.
`include "middle_access_stack_core_defines.svh"

module middle_access_stack_core #(
    parameter int DEPTH = mas_pkg::DEPTH_DEF,
    parameter int GROUP = mas_pkg::GROUP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [1:0] func, [33:2] push_value, [39:34] zero
    input  logic [mas_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // master side
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] middle_value, [33:32] status, [40:34] entry_count, [47:41] zero
    output logic [mas_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_TAP  = 3'd2;
    localparam logic [2:0] S_GRP  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                         r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [mas_pkg::FUNC_W-1:0]         r_func;
    logic [mas_pkg::DATA_W-1:0]         r_value;
    logic [mas_pkg::STATUS_W-1:0]       r_status, n_status;

    logic [CW-1:0]                      w_mid;
    logic                               w_in_xfer;
    logic                               w_upd;
    logic [CW+mas_pkg::CNT_OUT_W-1:0]   w_count_ext;
    logic [mas_pkg::DATA_W-1:0]         w_mid_word;

    mas_pkg::t_cell_ctl                 w_ctl   [DEPTH];
    logic [mas_pkg::DATA_W-1:0]         w_data  [DEPTH];
    logic [mas_pkg::DATA_W-1:0]         w_upper [DEPTH];
    logic [mas_pkg::DATA_W-1:0]         w_taps  [DEPTH];

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_upd     = (r_state == S_UPD);
    assign w_mid     = r_count >> 1;

    // Operation decode: new count and status, applied in the update cycle.
    always_comb begin
        n_count  = r_count;
        n_status = mas_pkg::ST_OK;
        if (r_func == mas_pkg::OP_PUSH) begin
            if (r_count == CW'(DEPTH)) begin
                n_status = mas_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (r_count == '0) begin
            n_status = mas_pkg::ST_EMPTY;
        end else if (r_func == mas_pkg::OP_POP || r_func == mas_pkg::OP_DELETE) begin
            n_count = r_count - CW'(1);
        end
    end

    // Per-cell controls. Cell i is written by a push when i equals the count,
    // and shifts down on a delete when it lies in [mid, count-2].
    for (genvar i = 0; i < DEPTH; i++) begin : g_cells
        always_comb begin
            w_ctl[i].push_wr = w_upd && (r_func == mas_pkg::OP_PUSH)
                               && (CW'(i) == r_count);
            w_ctl[i].shift   = w_upd && (r_func == mas_pkg::OP_DELETE)
                               && (r_count != '0)
                               && (CW'(i) >= w_mid)
                               && (CW'(i + 1) < r_count);
            w_ctl[i].sel     = (r_count != '0) && (CW'(i) == w_mid);
        end

        if (i == DEPTH - 1) begin : g_top
            assign w_upper[i] = w_data[i];
        end else begin : g_mid
            assign w_upper[i] = w_data[i + 1];
        end

        mas_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[i]),
            .i_push_value (r_value),
            .i_upper      (w_upper[i]),
            .o_data       (w_data[i]),
            .o_tap        (w_taps[i])
        );
    end

    mas_mid_tree #(
        .DEPTH (DEPTH),
        .GROUP (GROUP)
    ) u_mid_tree (
        .i_clk  (i_clk),
        .i_taps (w_taps),
        .o_word (w_mid_word)
    );

    // Sequencer: accept, update cells, wait out the tree latency, then hold the result until taken.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_UPD;
            S_UPD:  n_state = S_TAP;
            S_TAP:  n_state = S_GRP;
            S_GRP:  n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT:  if (i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_upd) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func  <= i_s_axis_tdata[mas_pkg::FUNC_W-1:0];
            r_value <= i_s_axis_tdata[mas_pkg::FUNC_W +: mas_pkg::DATA_W];
        end
        if (w_upd) begin
            r_status <= n_status;
        end
    end

    // entry_count is the count masked to seven bits
    assign w_count_ext = {{mas_pkg::CNT_OUT_W{1'b0}}, r_count};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {
        {(mas_pkg::OUT_TDATA_W - mas_pkg::DATA_W - mas_pkg::STATUS_W
          - mas_pkg::CNT_OUT_W){1'b0}},
        w_count_ext[mas_pkg::CNT_OUT_W-1:0],
        r_status,
        w_mid_word
    };

    // Checks
    `MAS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `MAS_ASSERT_NEVER(a_one_in_flight, i_clk, i_rst_n, o_s_axis_tready && o_m_axis_tvalid, "accepting while a result is pending")
    `MAS_ASSERT(a_full_holds, i_clk, i_rst_n, (w_upd && r_func == mas_pkg::OP_PUSH && r_count == CW'(DEPTH)) |=> (r_count == CW'(DEPTH) && r_status == mas_pkg::ST_FULL), "refused push changed the stack")
    `MAS_ASSERT(a_empty_result, i_clk, i_rst_n, (o_m_axis_tvalid && r_status == mas_pkg::ST_EMPTY) |-> (r_count == '0 && w_mid_word == '0), "empty result carries data")

endmodule

/* verif/tb_middle_access_stack_core.sv */
`timescale 1ns / 100ps

module tb_middle_access_stack_core;

    localparam int STACK_DEPTH = mas_pkg::DEPTH_DEF;
    localparam int RAND_ITEMS  = 400;
    localparam int HOLD_CYCLES = 120;   // long output stall, fills the block
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;    // wait after the drain loop before the final check

    // One result transfer, laid out as on o_m_axis_tdata (lowest field last here).
    typedef struct packed {
        logic [mas_pkg::CNT_OUT_W-1:0] entry_count;
        logic [mas_pkg::STATUS_W-1:0]  status;
        logic [mas_pkg::DATA_W-1:0]    middle_value;
    } t_stack_view;

    typedef struct packed {
        logic [mas_pkg::FUNC_W-1:0] op;
        logic [mas_pkg::DATA_W-1:0] word;
        logic                       typed;   // view below is the known answer
        t_stack_view                view;
    } t_probe_row;

    typedef enum logic [1:0] {GEN_FILL, GEN_DRAIN, GEN_MIX} t_gen_mode;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // [1:0] func, [33:2] push_value, [39:34] zero
    logic [mas_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // [31:0] middle_value, [33:32] status, [40:34] entry_count, [47:41] zero
    logic [mas_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    middle_access_stack_core #(
        .DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Directed walk: empty-stack ops, signed extremes, middle delete with odd
    // and even counts, pop from two entries, a delete that empties the stack.
    t_probe_row probe_rows [0:18] = '{
        '{mas_pkg::OP_POP,    32'h1234_5678, 1'b1, '{7'd0, mas_pkg::ST_EMPTY, 32'h0000_0000}},
        '{mas_pkg::OP_READ,   32'h1234_5678, 1'b1, '{7'd0, mas_pkg::ST_EMPTY, 32'h0000_0000}},
        '{mas_pkg::OP_DELETE, 32'h1234_5678, 1'b1, '{7'd0, mas_pkg::ST_EMPTY, 32'h0000_0000}},
        '{mas_pkg::OP_PUSH,   32'h7FFF_FFFF, 1'b1, '{7'd1, mas_pkg::ST_OK,    32'h7FFF_FFFF}},
        '{mas_pkg::OP_PUSH,   32'h8000_0000, 1'b1, '{7'd2, mas_pkg::ST_OK,    32'h8000_0000}},
        '{mas_pkg::OP_PUSH,   32'h0000_0000, 1'b1, '{7'd3, mas_pkg::ST_OK,    32'h8000_0000}},
        '{mas_pkg::OP_PUSH,   32'hFFFF_FFFF, 1'b1, '{7'd4, mas_pkg::ST_OK,    32'h0000_0000}},
        '{mas_pkg::OP_READ,   32'hFFFF_FFFF, 1'b1, '{7'd4, mas_pkg::ST_OK,    32'h0000_0000}},
        '{mas_pkg::OP_DELETE, 32'h1234_5678, 1'b1, '{7'd3, mas_pkg::ST_OK,    32'h8000_0000}},
        '{mas_pkg::OP_DELETE, 32'h1234_5678, 1'b1, '{7'd2, mas_pkg::ST_OK,    32'hFFFF_FFFF}},
        '{mas_pkg::OP_POP,    32'h1234_5678, 1'b1, '{7'd1, mas_pkg::ST_OK,    32'h7FFF_FFFF}},
        '{mas_pkg::OP_DELETE, 32'h1234_5678, 1'b1, '{7'd0, mas_pkg::ST_OK,    32'h0000_0000}},
        '{mas_pkg::OP_PUSH,   32'h5555_5555, 1'b0, '0},
        '{mas_pkg::OP_PUSH,   32'hAAAA_AAAA, 1'b0, '0},
        '{mas_pkg::OP_PUSH,   32'h0000_0001, 1'b0, '0},
        '{mas_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b0, '0},
        '{mas_pkg::OP_READ,   32'h0000_0000, 1'b0, '0},
        '{mas_pkg::OP_POP,    32'hAAAA_AAAA, 1'b0, '0},
        '{mas_pkg::OP_POP,    32'h5555_5555, 1'b0, '0}
    };

    // stack shadow
    logic [mas_pkg::DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                         stack_count = 0;
    t_stack_view                pending_views [$];

    int          err_count = 0;
    bit          cur_typed = 1'b0;
    t_stack_view cur_view = '0;

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 87;
    bit          hold_req = 1'b0;

    // Applies one operation to the shadow stack, returns what the block reports.
    function automatic t_stack_view apply_stack_op(input logic [mas_pkg::FUNC_W-1:0] op,
                                                   input logic [mas_pkg::DATA_W-1:0] word);
        t_stack_view r;
        int          idx;
        r = '0;
        r.status = mas_pkg::ST_OK;
        if (op == mas_pkg::OP_PUSH) begin
            if (stack_count >= STACK_DEPTH) begin
                r.status = mas_pkg::ST_FULL;
            end else begin
                stack_mem[stack_count] = word;
                stack_count++;
            end
        end else if (stack_count == 0) begin
            r.status = mas_pkg::ST_EMPTY;
        end else if (op == mas_pkg::OP_POP) begin
            stack_count--;
        end else if (op == mas_pkg::OP_DELETE) begin
            // close the gap: everything above the middle drops one place
            for (idx = stack_count / 2; idx < stack_count - 1; idx++)
                stack_mem[idx] = stack_mem[idx + 1];
            stack_count--;
        end
        r.middle_value = (stack_count == 0) ? '0 : stack_mem[stack_count / 2];
        r.entry_count  = stack_count[mas_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic note_error(input string what, input t_stack_view want,
                              input t_stack_view got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR %s: expected mid %h st %0d cnt %0d, got mid %h st %0d cnt %0d",
                     what, want.middle_value, want.status, want.entry_count,
                     got.middle_value, got.status, got.entry_count);
    endtask

    // Scoreboard: results are retired before the same-edge input is predicted.
    always @(posedge i_clk) begin
        t_stack_view got;
        t_stack_view want;
        t_stack_view model_view;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[$bits(t_stack_view)-1:0];
                if (pending_views.size() == 0) begin
                    note_error("unexpected result", '0, got);
                end else begin
                    want = pending_views.pop_front();
                    if (got.middle_value !== want.middle_value ||
                        got.status !== want.status ||
                        got.entry_count !== want.entry_count)
                        note_error("result mismatch", want, got);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                model_view = apply_stack_op(
                    i_s_axis_tdata[mas_pkg::FUNC_W-1:0],
                    i_s_axis_tdata[mas_pkg::FUNC_W+mas_pkg::DATA_W-1:mas_pkg::FUNC_W]);
                pending_views.push_back(cur_typed ? cur_view : model_view);
            end
        end
    end

    // Output side: random back-pressure, or a long hold-off when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(input logic [mas_pkg::FUNC_W-1:0] op,
                           input logic [mas_pkg::DATA_W-1:0] word,
                           input bit typed, input t_stack_view view);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_view  = view;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(mas_pkg::IN_TDATA_W-mas_pkg::FUNC_W-mas_pkg::DATA_W){1'b0}},
                            word, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [mas_pkg::DATA_W-1:0] pick_word();
        if ($urandom_range(7) != 0)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [mas_pkg::FUNC_W-1:0] pick_op(input t_gen_mode mode);
        int unsigned roll;
        roll = $urandom_range(99);
        case (mode)
            GEN_FILL: begin
                if (roll < 85)      return mas_pkg::OP_PUSH;
                else if (roll < 90) return mas_pkg::OP_POP;
                else if (roll < 95) return mas_pkg::OP_READ;
                else                return mas_pkg::OP_DELETE;
            end
            GEN_DRAIN: begin
                if (roll < 42)      return mas_pkg::OP_POP;
                else if (roll < 84) return mas_pkg::OP_DELETE;
                else if (roll < 92) return mas_pkg::OP_READ;
                else                return mas_pkg::OP_PUSH;
            end
            default: begin
                if (roll < 25)      return mas_pkg::OP_PUSH;
                else if (roll < 50) return mas_pkg::OP_POP;
                else if (roll < 75) return mas_pkg::OP_READ;
                else                return mas_pkg::OP_DELETE;
            end
        endcase
    endfunction

    initial begin
        t_gen_mode mode;
        int        bound_hits;
        int        mix_left;
        int        drain_cycles;
        mode         = GEN_FILL;
        bound_hits   = 0;
        mix_left     = 0;
        drain_cycles = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probe_rows[r])
            send_op(probe_rows[r].op, probe_rows[r].word, probe_rows[r].typed,
                    probe_rows[r].view);

        // Random part: fill to the top and beyond, drain to empty and beyond,
        // then a loose mix; repeat. The shadow count is current at each pick.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == 0) begin
                hold_req = 1'b1;
            end else if (k == RAND_ITEMS / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 14;
                hold_req      = 1'b1;
            end else if (k == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            case (mode)
                GEN_FILL: begin
                    if (stack_count == STACK_DEPTH)
                        bound_hits++;
                    if (bound_hits >= 4) begin
                        mode       = GEN_DRAIN;
                        bound_hits = 0;
                    end
                end
                GEN_DRAIN: begin
                    if (stack_count == 0)
                        bound_hits++;
                    if (bound_hits >= 3) begin
                        mode       = GEN_MIX;
                        bound_hits = 0;
                        mix_left   = $urandom_range(20, 60);
                    end
                end
                default: begin
                    mix_left--;
                    if (mix_left <= 0)
                        mode = GEN_FILL;
                end
            endcase
            send_op(pick_op(mode), pick_word(), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_views.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_views.size() != 0)
            note_error("result missing", pending_views[0], '0);

        if (err_count == 0)
            $display("tb_middle_access_stack_core: done, clean");
        else
            $display("tb_middle_access_stack_core: done, errors");
        $finish;
    end

    // ~420 items, each with its worst-case stalls, stay far below this.
    initial begin
        #5_000_000;
        $display("tb_middle_access_stack_core: done, errors");
        $finish;
    end

endmodule
